// ----- rtl/core/line_start_index_search_macros.svh -----
// Assertion macros for the line start index search block.
`ifndef LINE_START_INDEX_SEARCH_MACROS_SVH
`define LINE_START_INDEX_SEARCH_MACROS_SVH

`ifndef SYNTH
// Implication checked in the same cycle.
`define LSIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line start index search check failed");
// Implication checked in the cycle after the antecedent.
`define LSIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line start index search check failed");
`else
`define LSIS_ASSERT_NOW(label, ante, cons)
`define LSIS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/lsis_pkg.sv -----
package lsis_pkg;

  localparam int MAX_LINES = 1024;
  localparam int POS_WIDTH = 20;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int LINE_W    = 10;
  localparam int BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_FIND = 1'b1
  } op_t;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic signed [CNT_W:0] sidx_t;

endpackage

// ----- rtl/core/lsis_in_if.sv -----
interface lsis_in_if;
  import lsis_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] byte_value;
  logic              last_byte;
  pos_t              location;

  modport source (output valid, op, byte_value, last_byte, location, input ready);
  modport sink (input valid, op, byte_value, last_byte, location, output ready);
endinterface

// ----- rtl/core/lsis_out_if.sv -----
interface lsis_out_if;
  import lsis_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_index;
  logic              table_overflow;

  modport source (output valid, line_index, table_overflow, input ready);
  modport sink (input valid, line_index, table_overflow, output ready);
endinterface

// ----- rtl/core/line_start_index_search.sv -----
// Channel   Direction  Carries
// in_ch     sink       op, byte_value, last_byte, location
// out_ch    source     line_index, table_overflow (one transaction per lookup)
//
// A scan transaction is taken in S_IDLE and produces no result. A lookup
// runs a setup step in S_IDLE, an S_ADDR/S_CMP pair per probe of the binary
// search, an S_FADDR/S_FCMP pair for the final probe, then S_DONE, which
// loads the result register once the output is free. An exact match, or a
// table with a single entry, goes straight to S_DONE. The registered read
// port of the line start memory is why each probe needs an address state.
// Reset is synchronous; no clearing pass runs. in_ch is stalled during a lookup.
`include "line_start_index_search_macros.svh"

module line_start_index_search
  import lsis_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  lsis_in_if.sink      in_ch,
  lsis_out_if.source   out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_CMP,
    S_FADDR,
    S_FCMP,
    S_DONE
  } state_t;

  localparam int SUM_W = CNT_W + 2;

  state_t            state_r;
  pos_t              mem_r [MAX_LINES];
  pos_t              rd_data_r;
  cnt_t              line_count_r;
  pos_t              scan_pos_r;
  logic              start_fresh_r;
  logic              ovf_r;
  pos_t              loc_r;
  sidx_t             lo_r;
  sidx_t             hi_r;
  sidx_t             idx_r;
  logic [IDX_W-1:0]  res_r;
  logic              out_valid_r;
  logic [LINE_W-1:0] out_line_r;
  logic              out_ovf_r;

  logic              in_acc;
  logic              scan_acc;
  logic              find_acc;
  cnt_t              eff_count;
  pos_t              eff_pos;
  logic              eff_ovf;
  logic              nl_write;
  logic signed [SUM_W-1:0] mid_sum;
  sidx_t             mid;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  pos_t              probe_val;
  sidx_t             lo_step;
  sidx_t             hi_step;
  logic              out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign scan_acc    = in_acc && (in_ch.op == OP_SCAN);
  assign find_acc    = in_acc && (in_ch.op == OP_FIND);

  assign eff_count = start_fresh_r ? cnt_t'(1) : line_count_r;
  assign eff_pos   = start_fresh_r ? '0 : scan_pos_r;
  assign eff_ovf   = start_fresh_r ? 1'b0 : ovf_r;
  assign nl_write  = scan_acc && (in_ch.byte_value == NEWLINE_BYTE)
                     && (eff_count < cnt_t'(MAX_LINES));

  assign mid_sum = SUM_W'(lo_r) + SUM_W'(hi_r);
  assign mid     = sidx_t'(mid_sum >>> 1);
  assign rd_addr = (state_r == S_ADDR) ? mid[IDX_W-1:0] : lo_r[IDX_W-1:0];
  assign rd_en   = (state_r == S_ADDR) || (state_r == S_FADDR);

  // Entry 0 is never written and always reads as zero.
  assign probe_val = (idx_r[IDX_W-1:0] == '0) ? '0 : rd_data_r;
  assign lo_step   = idx_r + sidx_t'(1);
  assign hi_step   = idx_r - sidx_t'(1);
  assign out_free  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (nl_write) begin
      mem_r[eff_count[IDX_W-1:0]] <= eff_pos + pos_t'(1);
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      line_count_r  <= cnt_t'(1);
      scan_pos_r    <= '0;
      start_fresh_r <= 1'b0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (scan_acc) begin
            line_count_r  <= nl_write ? eff_count + cnt_t'(1) : eff_count;
            ovf_r         <= eff_ovf || ((in_ch.byte_value == NEWLINE_BYTE) && !nl_write);
            scan_pos_r    <= eff_pos + pos_t'(1);
            start_fresh_r <= in_ch.last_byte;
          end else if (find_acc) begin
            loc_r <= in_ch.location;
            lo_r  <= '0;
            hi_r  <= sidx_t'({1'b0, line_count_r}) - sidx_t'(1);
            if (line_count_r <= cnt_t'(1)) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          idx_r   <= mid;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (probe_val == loc_r) begin
            res_r   <= idx_r[IDX_W-1:0];
            state_r <= S_DONE;
          end else if (probe_val < loc_r) begin
            lo_r    <= lo_step;
            state_r <= (lo_step < hi_r) ? S_ADDR : S_FADDR;
          end else begin
            hi_r    <= hi_step;
            state_r <= (lo_r < hi_step) ? S_ADDR : S_FADDR;
          end
        end
        S_FADDR: begin
          idx_r   <= lo_r;
          state_r <= S_FCMP;
        end
        S_FCMP: begin
          if ((probe_val > loc_r) && (idx_r > sidx_t'(0))) begin
            res_r <= hi_step[IDX_W-1:0];
          end else if (probe_val > loc_r) begin
            res_r <= '0;
          end else begin
            res_r <= idx_r[IDX_W-1:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_line_r  <= LINE_W'(res_r);
            out_ovf_r   <= ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_index     = out_line_r;
  assign out_ch.table_overflow = out_ovf_r;

  `LSIS_ASSERT_NOW(a_count_range, 1'b1,
    (line_count_r != '0) && (line_count_r <= cnt_t'(MAX_LINES)))
  `LSIS_ASSERT_NOW(a_ovf_full, ovf_r && !start_fresh_r,
    line_count_r == cnt_t'(MAX_LINES))
  `LSIS_ASSERT_NOW(a_probe_bounds, state_r == S_ADDR, lo_r < hi_r)
  `LSIS_ASSERT_NOW(a_result_range, state_r == S_DONE,
    cnt_t'(res_r) < line_count_r)
  `LSIS_ASSERT_NEXT(a_single_entry, find_acc && (line_count_r == cnt_t'(1)),
    (state_r == S_DONE) && (res_r == '0))

endmodule
